// ----- sv/kz_pkg.sv -----
// Package: cipher constants, S-box table and GF(2^8) linear-layer functions.
`default_nettype none
package kz_pkg;
	localparam int BLK_W  = 128;
	localparam int WORD_W = 64;
	localparam int NRK    = 10;
	localparam int CFG_IW = 3;
	localparam logic [8:0] POLY = 9'h1C3;

	localparam logic [CFG_IW-1:0] REG_KEY0 = 3'd0;
	localparam logic [CFG_IW-1:0] REG_KEY1 = 3'd1;
	localparam logic [CFG_IW-1:0] REG_KEY2 = 3'd2;
	localparam logic [CFG_IW-1:0] REG_KEY3 = 3'd3;

	localparam logic [7:0] SBOX [256] = '{
		8'd252, 8'd238, 8'd221, 8'd17, 8'd207, 8'd110, 8'd49, 8'd22,
		8'd251, 8'd196, 8'd250, 8'd218, 8'd35, 8'd197, 8'd4, 8'd77,
		8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46, 8'd153, 8'd186,
		8'd23, 8'd54, 8'd241, 8'd187, 8'd20, 8'd205, 8'd95, 8'd193,
		8'd249, 8'd24, 8'd101, 8'd90, 8'd226, 8'd92, 8'd239, 8'd33,
		8'd129, 8'd28, 8'd60, 8'd66, 8'd139, 8'd1, 8'd142, 8'd79,
		8'd5, 8'd132, 8'd2, 8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
		8'd6, 8'd11, 8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
		8'd235, 8'd52, 8'd44, 8'd81, 8'd234, 8'd200, 8'd72, 8'd171,
		8'd242, 8'd42, 8'd104, 8'd162, 8'd253, 8'd58, 8'd206, 8'd204,
		8'd181, 8'd112, 8'd14, 8'd86, 8'd8, 8'd12, 8'd118, 8'd18,
		8'd191, 8'd114, 8'd19, 8'd71, 8'd156, 8'd183, 8'd93, 8'd135,
		8'd21, 8'd161, 8'd150, 8'd41, 8'd16, 8'd123, 8'd154, 8'd199,
		8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
		8'd50, 8'd117, 8'd25, 8'd61, 8'd255, 8'd53, 8'd138, 8'd126,
		8'd109, 8'd84, 8'd198, 8'd128, 8'd195, 8'd189, 8'd13, 8'd87,
		8'd223, 8'd245, 8'd36, 8'd169, 8'd62, 8'd168, 8'd67, 8'd201,
		8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34, 8'd185, 8'd3,
		8'd224, 8'd15, 8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
		8'd220, 8'd232, 8'd40, 8'd80, 8'd78, 8'd51, 8'd10, 8'd74,
		8'd167, 8'd151, 8'd96, 8'd115, 8'd30, 8'd0, 8'd98, 8'd68,
		8'd26, 8'd184, 8'd56, 8'd130, 8'd100, 8'd159, 8'd38, 8'd65,
		8'd173, 8'd69, 8'd70, 8'd146, 8'd39, 8'd94, 8'd85, 8'd47,
		8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
		8'd7, 8'd88, 8'd179, 8'd64, 8'd134, 8'd172, 8'd29, 8'd247,
		8'd48, 8'd55, 8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
		8'd225, 8'd27, 8'd131, 8'd73, 8'd76, 8'd63, 8'd248, 8'd254,
		8'd141, 8'd83, 8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
		8'd32, 8'd113, 8'd103, 8'd164, 8'd45, 8'd43, 8'd9, 8'd91,
		8'd203, 8'd155, 8'd37, 8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
		8'd89, 8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
		8'd209, 8'd102, 8'd175, 8'd194, 8'd57, 8'd75, 8'd99, 8'd182
	};

	localparam logic [7:0] LCOEF [16] = '{
		8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
		8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
	};

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] x;
		logic [7:0] acc;
		x = {1'b0, a};
		acc = '0;
		for (int n = 0; n < 8; n++) begin
			if (b[n]) acc = acc ^ x[7:0];
			x = {x[7:0], 1'b0};
			if (x[8]) x = x ^ POLY;
		end
		return acc;
	endfunction

	function automatic logic [BLK_W-1:0] r_step(input logic [BLK_W-1:0] v);
		logic [7:0] t;
		t = '0;
		for (int j = 0; j < 16; j++) t = t ^ gf_mul(LCOEF[j], v[8*j +: 8]);
		return {v[BLK_W-9:0], t};
	endfunction
endpackage
`default_nettype wire

// ----- sv/kz_if.sv -----
// Interfaces: plaintext request channel and ciphertext result channel.
`default_nettype none
interface kz_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] plain_low;
	logic [63:0] plain_high;
	modport source (output valid, output plain_low, output plain_high, input ready);
	modport sink (input valid, input plain_low, input plain_high, output ready);
endinterface

interface kz_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_low;
	logic [63:0] cipher_high;
	modport source (output valid, output cipher_low, output cipher_high, input ready);
	modport sink (input valid, input cipher_low, input cipher_high, output ready);
endinterface
`default_nettype wire

// ----- sv/kz_round.sv -----
// Shared round unit: optional key XOR and S-box, then four steps of the linear layer.
`default_nettype none
module kz_round (
	input  wire logic [kz_pkg::BLK_W-1:0] din,
	input  wire logic [kz_pkg::BLK_W-1:0] key,
	input  wire logic                     sub,
	output logic      [kz_pkg::BLK_W-1:0] dout
);
	import kz_pkg::*;

	logic [BLK_W-1:0] x;

	always_comb begin
		x = din;
		if (sub) begin
			for (int i = 0; i < 16; i++) x[8*i +: 8] = SBOX[din[8*i +: 8] ^ key[8*i +: 8]];
		end
		for (int s = 0; s < 4; s++) x = r_step(x);
		dout = x;
	end
endmodule
`default_nettype wire

// ----- sv/block_cipher_128_encrypt_core.sv -----
// Top level: 128-bit block encryption core with key schedule and round-key store.
//
//  channel    dir  handshake          payload
//  plain_ch   in   valid/ready        plain_low, plain_high
//  cipher_ch  out  valid/ready        cipher_low, cipher_high
//  cfg        in   cfg_we             cfg_idx, cfg_wdata
//
// Encryption runs the accept, nine rounds of four phases each through the shared
// round unit, and the final XOR, which waits while an untaken result is held.
// After a key write the first request first runs the schedule: 32 steps of
// eight phases each on the same unit, ahead of encryption.
// The result waits in the output register; a new request is taken meanwhile.
// Reset clears control state; round keys are rebuilt before first use.
`default_nettype none
module block_cipher_128_encrypt_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [kz_pkg::CFG_IW-1:0] cfg_idx,
	input  wire logic [kz_pkg::WORD_W-1:0] cfg_wdata,
	kz_in_if.sink                          plain_ch,
	kz_out_if.source                       cipher_ch
);
	import kz_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_KINIT = 3'd1;
	localparam logic [2:0] ST_KEXP  = 3'd2;
	localparam logic [2:0] ST_KFIN  = 3'd3;
	localparam logic [2:0] ST_ENC   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]        st_q;
	logic [2:0]        ph_q;
	logic [4:0]        i_q;
	logic [3:0]        rnd_q;
	logic              kready_q;
	logic              pend_q;
	logic [3:0]        pa_q;
	logic [BLK_W-1:0]  pd_q;
	logic [BLK_W-1:0]  a_q, b_q, w_q, blk_q, rk_q;
	logic [WORD_W-1:0] kw_q [4];
	logic              ov_q;
	logic [BLK_W-1:0]  out_q;

	logic [BLK_W-1:0]  mem [NRK];

	logic [BLK_W-1:0]  u_din, u_key, u_out, t_val;
	logic              u_sub;
	logic              acc;
	logic              wr_en, rd_en;
	logic [3:0]        wa, ra;
	logic [BLK_W-1:0]  wd;
	logic [2:0]        kp;

	kz_round u_round (.din(u_din), .key(u_key), .sub(u_sub), .dout(u_out));

	assign plain_ch.ready       = (st_q == ST_IDLE);
	assign acc                  = plain_ch.valid && plain_ch.ready;
	assign cipher_ch.valid      = ov_q;
	assign cipher_ch.cipher_low  = out_q[63:0];
	assign cipher_ch.cipher_high = out_q[127:64];
	assign t_val                = u_out ^ b_q;
	assign kp                   = {1'b0, i_q[4:3]} + 3'd1;

	always_comb begin
		u_din = w_q;
		u_key = w_q;
		u_sub = 1'b0;
		if (st_q == ST_ENC) begin
			u_key = rk_q;
			u_sub = (ph_q[1:0] == 2'd0);
		end else begin
			if (ph_q == 3'd0) u_din = {({3'b0, i_q} + 8'd1), 120'b0};
			if (ph_q == 3'd4) begin
				u_din = a_q;
				u_sub = 1'b1;
			end
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wa    = '0;
		wd    = a_q;
		if (st_q == ST_KINIT) begin
			wr_en = 1'b1;
		end else if (pend_q) begin
			wr_en = 1'b1;
			wa    = pa_q;
			wd    = pd_q;
		end else if (st_q == ST_KEXP && ph_q == 3'd7 && i_q[2:0] == 3'd7) begin
			wr_en = 1'b1;
			wa    = {kp, 1'b0};
			wd    = t_val;
		end
		rd_en = (acc && kready_q) || (st_q == ST_KFIN) || (st_q == ST_ENC && ph_q[1:0] == 2'd3);
		ra    = (st_q == ST_ENC) ? rnd_q + 4'd1 : 4'd0;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wa] <= wd;
		if (rd_en) rk_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ph_q     <= '0;
			i_q      <= '0;
			rnd_q    <= '0;
			kready_q <= 1'b0;
			pend_q   <= 1'b0;
			ov_q     <= 1'b0;
			for (int k = 0; k < 4; k++) kw_q[k] <= '0;
		end else begin
			pend_q <= 1'b0;
			if (cipher_ch.ready) ov_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
						kw_q[cfg_idx[1:0]] <= cfg_wdata;
						kready_q <= 1'b0;
					end
					default: ;
				endcase
			end
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						blk_q <= {plain_ch.plain_high, plain_ch.plain_low};
						w_q   <= {plain_ch.plain_high, plain_ch.plain_low};
						a_q   <= {kw_q[1], kw_q[0]};
						b_q   <= {kw_q[3], kw_q[2]};
						ph_q  <= '0;
						rnd_q <= '0;
						st_q  <= kready_q ? ST_ENC : ST_KINIT;
					end
				end
				ST_KINIT: begin
					pend_q <= 1'b1;
					pa_q   <= 4'd1;
					pd_q   <= b_q;
					i_q    <= '0;
					ph_q   <= '0;
					st_q   <= ST_KEXP;
				end
				ST_KEXP: begin
					w_q  <= u_out;
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd7) begin
						a_q <= t_val;
						b_q <= a_q;
						if (i_q[2:0] == 3'd7) begin
							pend_q <= 1'b1;
							pa_q   <= {kp, 1'b1};
							pd_q   <= a_q;
						end
						if (i_q == 5'd31) st_q <= ST_KFIN;
						else i_q <= i_q + 5'd1;
					end
				end
				ST_KFIN: begin
					kready_q <= 1'b1;
					w_q      <= blk_q;
					ph_q     <= '0;
					rnd_q    <= '0;
					st_q     <= ST_ENC;
				end
				ST_ENC: begin
					w_q  <= u_out;
					ph_q <= ph_q + 3'd1;
					if (ph_q[1:0] == 2'd3) begin
						ph_q <= '0;
						if (rnd_q == 4'd8) st_q <= ST_FIN;
						else rnd_q <= rnd_q + 4'd1;
					end
				end
				ST_FIN: begin
					if (!ov_q || cipher_ch.ready) begin
						out_q <= w_q ^ rk_q;
						ov_q  <= 1'b1;
						st_q  <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- verif/kz_tb_if.sv -----
// Testbench-side channel interfaces are the RTL ones; this file holds the shared predictor package.
`timescale 1ns / 1ps
package kz_tb_pkg;
	import kz_pkg::*;

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] x;
		logic [7:0] acc;
		x = {1'b0, a};
		acc = 8'h00;
		for (int n = 0; n < 8; n++) begin
			if (b[n]) acc ^= x[7:0];
			x = {x[7:0], 1'b0};
			if (x[8]) x ^= 9'h1C3;
		end
		return acc;
	endfunction

	function automatic logic [127:0] mix_linear(input logic [127:0] v);
		logic [7:0] t;
		for (int r = 0; r < 16; r++) begin
			t = 8'h00;
			for (int j = 0; j < 16; j++) t ^= gmul(LCOEF[j], v[8*j +: 8]);
			v = {v[119:0], t};
		end
		return v;
	endfunction

	function automatic logic [127:0] lsx(input logic [127:0] v, input logic [127:0] k);
		logic [127:0] s;
		for (int i = 0; i < 16; i++) s[8*i +: 8] = SBOX[v[8*i +: 8] ^ k[8*i +: 8]];
		return mix_linear(s);
	endfunction
endpackage

// ----- verif/kz_checker.sv -----
// Checker: watches both channels, predicts ciphertext and compares in order.
`timescale 1ns / 1ps
module kz_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [63:0] plain_low,
	input  wire logic [63:0] plain_high,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [63:0] cipher_low,
	input  wire logic [63:0] cipher_high,
	output int               errors,
	output int               pending
);
	import kz_tb_pkg::*;
	logic [63:0] key [4];
	logic [127:0] rkeys [10];
	bit keys_ok;
	logic [127:0] cipher_q [$];

	function automatic void build_schedule();
		logic [127:0] a, b, t, c;
		a = {key[1], key[0]};
		b = {key[3], key[2]};
		rkeys[0] = a;
		rkeys[1] = b;
		for (int i = 0; i < 32; i++) begin
			c = '0;
			c[127:120] = 8'(i + 1);
			c = mix_linear(c);
			t = lsx(a, c) ^ b;
			b = a;
			a = t;
			if ((i & 7) == 7) begin
				rkeys[(i + 1) / 4] = a;
				rkeys[(i + 1) / 4 + 1] = b;
			end
		end
		keys_ok = 1;
	endfunction

	function automatic logic [127:0] encrypt_block(input logic [127:0] v);
		if (!keys_ok) build_schedule();
		for (int r = 0; r < 9; r++) v = lsx(v, rkeys[r]);
		return v ^ rkeys[9];
	endfunction

	assign pending = cipher_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] exp_c;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key[i] = '0;
			keys_ok = 0;
			errors <= 0;
			cipher_q.delete();
		end else begin
			if (cfg_we && cfg_idx <= 3'd3) begin
				key[cfg_idx[1:0]] = cfg_wdata;
				keys_ok = 0;
			end
			if (in_valid && in_ready)
				cipher_q.push_back(encrypt_block({plain_high, plain_low}));
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					if (errors < 10) $display("unexpected result %h_%h", cipher_high, cipher_low);
					errors <= errors + 1;
				end else begin
					exp_c = cipher_q.pop_front();
					if (exp_c != {cipher_high, cipher_low}) begin
						if (errors < 10)
							$display("mismatch: expected %h_%h got %h_%h",
								exp_c[127:64], exp_c[63:0], cipher_high, cipher_low);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// ----- verif/tb_block_cipher_128_encrypt_core.sv -----
// Testbench top: clock, reset, key writes, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_block_cipher_128_encrypt_core;
	import kz_pkg::*;
	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IW-1:0] cfg_idx = '0;
	logic [63:0] cfg_wdata = '0;
	int errors, pending;
	int send_idle = 0, recv_stall = 0;
	bit hold_off = 0;
	int quiet = 0;

	kz_in_if plain_ch ();
	kz_out_if cipher_ch ();

	block_cipher_128_encrypt_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .plain_ch(plain_ch), .cipher_ch(cipher_ch)
	);

	kz_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .in_valid(plain_ch.valid), .in_ready(plain_ch.ready),
		.plain_low(plain_ch.plain_low), .plain_high(plain_ch.plain_high),
		.out_valid(cipher_ch.valid), .out_ready(cipher_ch.ready),
		.cipher_low(cipher_ch.cipher_low), .cipher_high(cipher_ch.cipher_high),
		.errors(errors), .pending(pending)
	);

	always #2 clk = ~clk;

	initial begin
		plain_ch.valid = 0;
		plain_ch.plain_low = '0;
		plain_ch.plain_high = '0;
		cipher_ch.ready = 0;
	end

	always @(posedge clk) begin
		if (!arst_n || hold_off) cipher_ch.ready <= 0;
		else cipher_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((plain_ch.valid && plain_ch.ready) || (cipher_ch.valid && cipher_ch.ready))
			quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("** block_cipher_128_encrypt_core: FAILED **");
			$finish;
		end
	end

	task automatic write_key(input logic [CFG_IW-1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
		while ($urandom_range(99) < send_idle) begin
			plain_ch.valid <= 0;
			@(posedge clk);
		end
		plain_ch.valid <= 1;
		plain_ch.plain_low <= lo;
		plain_ch.plain_high <= hi;
		@(posedge clk);
		while (!plain_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		plain_ch.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic load_key(input int mode);
		logic [63:0] w;
		for (int i = 0; i < 4; i++) begin
			w = (mode == 0) ? 64'h0 : (mode == 1) ? '1 : rnd64();
			write_key(CFG_IW'(i), w);
		end
	endtask

	initial begin
		logic [63:0] lo, hi;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
		send_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
		drain();
		load_key(1);
		send_block('0, '0);
		send_block('1, '1);
		drain();
		write_key(REG_KEY2, 64'h0011223344556677);
		write_key(3'd5, rnd64());
		send_block(64'h1, 64'h8000000000000000);
		drain();
		write_key(3'd7, rnd64());
		for (int i = 0; i < 8; i++) send_block(rnd64(), rnd64());
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 75; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 75; end
				default: begin send_idle = 38; recv_stall = 38; end
			endcase
			load_key(ph == 5 ? 0 : 2);
			if (ph == 0) begin
				hold_off = 1;
				fork
					begin repeat (600) @(posedge clk); hold_off = 0; end
				join_none
			end
			for (int i = 0; i < 155; i++) begin
				case ($urandom_range(3))
					0: begin lo = '0; hi = rnd64(); end
					1: begin lo = '1; hi = ~rnd64(); end
					default: begin lo = rnd64(); hi = rnd64(); end
				endcase
				send_block(lo, hi);
			end
			drain();
		end
		if (errors == 0 && pending == 0)
			$display("** block_cipher_128_encrypt_core: PASSED **");
		else
			$display("** block_cipher_128_encrypt_core: FAILED **");
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/kz_pkg.sv
sv/kz_if.sv
sv/kz_round.sv
sv/block_cipher_128_encrypt_core.sv
verif/kz_tb_if.sv
verif/kz_checker.sv
verif/tb_block_cipher_128_encrypt_core.sv
